// File: sv/masked_minmax_gray_normalizer_macros.svh
// Assertion macros shared by the checker of the gray normalizer.
`ifndef MASKED_MINMAX_GRAY_NORMALIZER_MACROS_SVH
`define MASKED_MINMAX_GRAY_NORMALIZER_MACROS_SVH

// Checks that c holds in the cycle after a, while reset is low.
`define MMGN_ASSERT_NEXT(lbl, clk, rst, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("mmgn assertion failed");

// Checks that c holds in the cycle after a, reset included.
`define MMGN_ASSERT_NEXT_ALWAYS(lbl, clk, a, c) \
  lbl: assert property (@(posedge clk) (a) |=> (c)) \
    else $error("mmgn assertion failed");

`endif

// File: sv/mmgn_pkg.sv
// Shared constants, types and helpers of the gray normalizer.
package mmgn_pkg;

  localparam int SAMPLE_BITS = 32;
  localparam int IN_W        = 32;
  localparam int DIV_W       = SAMPLE_BITS + 8;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  localparam logic [IN_W-1:0]        MARKER_RESET = 32'hFFFF_0000;
  localparam logic [SAMPLE_BITS-1:0] KEY_SIGN     = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
  localparam logic [7:0]             GRAY_FULL    = 8'd255;

  typedef enum logic [1:0] {
    CLS_ZERO,
    CLS_FULL,
    CLS_DIVIDE
  } cls_t;

  typedef struct packed {
    cls_t                   cls;
    logic [SAMPLE_BITS-1:0] off;
    logic [SAMPLE_BITS-1:0] span;
    logic                   last;
  } entry_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_PREP,
    BK_DIV,
    BK_DONE
  } back_state_t;

  // Maps a two's complement sample to an order-keeping offset-binary key.
  function automatic logic [SAMPLE_BITS-1:0] to_key(input logic [IN_W-1:0] v);
    logic [SAMPLE_BITS+IN_W-1:0] ext;
    ext = {{SAMPLE_BITS{1'b0}}, v};
    return ext[SAMPLE_BITS-1:0] ^ KEY_SIGN;
  endfunction

endpackage

// File: sv/mmgn_front.sv
// Front end: accepts items, keeps the frame statistics and classifies convert items.
module mmgn_front (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_valid,
  input  logic [31:0]           cfg_data,
  input  logic                  in_valid,
  input  logic                  in_stall,
  input  logic                  action,
  input  logic [31:0]           sample,
  input  logic                  frame_end,
  output logic                  push,
  output mmgn_pkg::entry_t      push_data
);
  import mmgn_pkg::*;

  logic [IN_W-1:0]        marker;
  logic [SAMPLE_BITS-1:0] running_min;
  logic [SAMPLE_BITS-1:0] running_max;
  logic                   seen_valid;

  logic [SAMPLE_BITS-1:0] key;
  logic                   kvalid;
  logic                   accept;

  always_comb begin
    key    = to_key(sample);
    kvalid = key != to_key(marker);
    accept = in_valid && !in_stall;
    push   = accept && action;

    push_data.off  = key - running_min;
    push_data.span = running_max - running_min;
    push_data.last = frame_end;
    if (!(kvalid && seen_valid && (running_max > running_min))) begin
      push_data.cls = CLS_ZERO;
    end else if (key <= running_min) begin
      push_data.cls = CLS_ZERO;
    end else if (key >= running_max) begin
      push_data.cls = CLS_FULL;
    end else begin
      push_data.cls = CLS_DIVIDE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      marker      <= MARKER_RESET;
      running_min <= '0;
      running_max <= '0;
      seen_valid  <= 1'b0;
    end else begin
      if (cfg_valid) begin
        marker <= cfg_data;
      end
      if (accept && !action && kvalid) begin
        if (!seen_valid) begin
          seen_valid  <= 1'b1;
          running_min <= key;
          running_max <= key;
        end else begin
          if (key > running_max) begin
            running_max <= key;
          end
          if (key < running_min) begin
            running_min <= key;
          end
        end
      end
      // The last convert beat of a frame clears the statistics for the next frame.
      if (push && frame_end) begin
        running_min <= '0;
        running_max <= '0;
        seen_valid  <= 1'b0;
      end
    end
  end

endmodule

// File: sv/mmgn_queue.sv
// Short register queue between the front end and the divider back end.
module mmgn_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  mmgn_pkg::entry_t  push_data,
  input  logic              pop,
  output mmgn_pkg::entry_t  pop_data,
  output logic              full,
  output logic              empty
);
  import mmgn_pkg::*;

  entry_t            slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;

  assign full     = count == (QPTR_W+1)'(QUEUE_DEPTH);
  assign empty    = count == '0;
  assign pop_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// File: sv/mmgn_back.sv
// Back end: restoring divider for the gray value and the output register.
module mmgn_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              empty,
  input  mmgn_pkg::entry_t  pop_data,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [7:0]        gray,
  output logic              frame_last
);
  import mmgn_pkg::*;

  back_state_t      state;
  back_state_t      state_next;
  entry_t           ent;
  logic [DIV_W-1:0] rem;
  logic [DIV_W-1:0] den;
  logic [7:0]       quot;
  logic [2:0]       step;
  logic             ge;
  logic             load_out;

  always_comb begin
    state_next = state;
    pop        = 1'b0;
    load_out   = 1'b0;
    ge         = rem >= den;
    case (state)
      BK_IDLE: begin
        if (!empty) begin
          pop        = 1'b1;
          state_next = (pop_data.cls == CLS_DIVIDE) ? BK_PREP : BK_DONE;
        end
      end
      BK_PREP: state_next = BK_DIV;
      BK_DIV: begin
        if (step == '0) begin
          state_next = BK_DONE;
        end
      end
      BK_DONE: begin
        if (!out_valid || !out_stall) begin
          load_out   = 1'b1;
          state_next = BK_IDLE;
        end
      end
      default: state_next = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      BK_IDLE: begin
        if (pop) begin
          ent  <= pop_data;
          quot <= (pop_data.cls == CLS_FULL) ? GRAY_FULL : 8'd0;
        end
      end
      BK_PREP: begin
        // 255 * off as a shift and subtract; the quotient then fits in eight bits.
        rem  <= {ent.off, 8'd0} - {8'd0, ent.off};
        den  <= {1'b0, ent.span, 7'd0};
        step <= 3'd7;
        quot <= '0;
      end
      BK_DIV: begin
        if (ge) begin
          rem <= rem - den;
        end
        den  <= den >> 1;
        quot <= {quot[6:0], ge};
        step <= step - 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      gray       <= quot;
      frame_last <= ent.last;
    end
  end

endmodule

// File: sv/masked_minmax_gray_normalizer.sv
// Top level of the masked min/max gray normalizer.
// Usage: the host streams each frame twice on the input channel (valid/stall,
// fields action, sample, frame_end). Scan beats (action 0) update the running
// minimum and maximum of samples that differ from the ignored marker and give
// no result. Convert beats (action 1) each give one gray beat on the output
// channel (out_valid/out_stall, fields gray, frame_last).
// The ignored marker is written through cfg_valid/cfg_ready/cfg_data while the
// block is idle, which the block does not enforce; cfg_ready is always high.
// Scan beats are taken one per cycle while stall is low. Convert beats enter
// a four-entry queue at one per cycle while it is not full. The back end
// passes a beat whose result is 0 or 255 through IDLE and DONE, and one
// that needs the eight-step restoring divider through IDLE, PREP, DIV and
// DONE; it pops no new beat before the last result is in the output register.
// Reset clears the statistics, empties the queue, drops out_valid and loads the
// marker with -1.0 in Q16.16. When the receiver stalls, the result holds in the
// output register, the queue fills and stall rises on the input channel.
module masked_minmax_gray_normalizer (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        action,
  input  logic [31:0] sample,
  input  logic        frame_end,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  gray,
  output logic        frame_last
);
  import mmgn_pkg::*;

  logic   push;
  logic   pop;
  logic   full;
  logic   empty;
  entry_t push_data;
  entry_t pop_data;

  assign cfg_ready = 1'b1;
  assign in_stall  = full;

  mmgn_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .action    (action),
    .sample    (sample),
    .frame_end (frame_end),
    .push      (push),
    .push_data (push_data)
  );

  mmgn_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .full      (full),
    .empty     (empty)
  );

  mmgn_back u_back (
    .clk        (clk),
    .rst        (rst),
    .empty      (empty),
    .pop_data   (pop_data),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .gray       (gray),
    .frame_last (frame_last)
  );

endmodule

// File: sv/mmgn_checker.sv
// Port-level checker of the gray normalizer and its bind to the top level.
`include "masked_minmax_gray_normalizer_macros.svh"

module mmgn_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [7:0]  gray,
  input logic        frame_last
);

  // A stalled result beat stays valid and keeps its payload.
  `MMGN_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid)
  `MMGN_ASSERT_NEXT(a_out_stable, clk, rst, out_valid && out_stall, $stable(gray) && $stable(frame_last))
  // Reset empties the queue and the output register.
  `MMGN_ASSERT_NEXT_ALWAYS(a_rst_out, clk, rst, !out_valid)
  `MMGN_ASSERT_NEXT_ALWAYS(a_rst_stall, clk, rst, !in_stall)

endmodule

bind masked_minmax_gray_normalizer mmgn_checker u_mmgn_checker (.*);

// File: tb/tb.sv
// Self-checking testbench of the masked min/max gray normalizer.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic        ACT_SCAN      = 1'b0;
  localparam logic        ACT_CONVERT   = 1'b1;
  localparam logic [31:0] KEY_FLIP      = 32'h8000_0000;
  localparam logic [31:0] SAMPLE_MIN    = 32'h8000_0000;
  localparam logic [31:0] SAMPLE_MAX    = 32'h7FFF_FFFF;
  localparam int          SETTLE_CYCLES = 24;
  localparam int          CYCLE_LIMIT   = 300000;
  localparam int          REPORT_LINES  = 100;

  typedef struct packed {
    logic [7:0] gray;
    logic       last;
  } gray_beat_t;

  // Tracks the frame statistics and holds the gray beats still owed by the block.
  class gray_scoreboard;
    logic [31:0] marker;
    logic [31:0] lo_key;
    logic [31:0] hi_key;
    bit          seen;
    gray_beat_t  expected_gray[$];
    int          errors;

    function new();
      marker = mmgn_pkg::MARKER_RESET;
      lo_key = '0;
      hi_key = '0;
      seen   = 1'b0;
      errors = 0;
    endfunction

    function int pending();
      return expected_gray.size();
    endfunction

    task report(string what);
      errors++;
      if (errors <= REPORT_LINES) $display("[%0t] gray mismatch: %s", $time, what);
    endtask

    function void note_sample(logic act, logic [31:0] smp, logic fend);
      logic [31:0] key;
      logic [39:0] off;
      logic [39:0] span;
      logic [39:0] scaled;
      gray_beat_t  beat;
      // Flipping the sign bit gives an unsigned key with the same order.
      key       = smp ^ KEY_FLIP;
      beat.gray = 8'd0;
      beat.last = fend;
      if (act == ACT_SCAN) begin
        if (smp != marker) begin
          if (!seen) begin
            seen   = 1'b1;
            lo_key = key;
            hi_key = key;
          end else begin
            if (key > hi_key) hi_key = key;
            if (key < lo_key) lo_key = key;
          end
        end
        return;
      end
      if (smp != marker && seen && hi_key > lo_key) begin
        if (key <= lo_key) begin
          beat.gray = 8'd0;
        end else if (key >= hi_key) begin
          beat.gray = 8'd255;
        end else begin
          off       = {8'd0, key - lo_key};
          span      = {8'd0, hi_key - lo_key};
          scaled    = (off * 40'd255) / span;
          beat.gray = scaled[7:0];
        end
      end
      expected_gray.push_back(beat);
      if (fend) begin
        seen   = 1'b0;
        lo_key = '0;
        hi_key = '0;
      end
    endfunction

    task check_gray(logic [7:0] g, logic last);
      gray_beat_t want;
      if (expected_gray.size() == 0) begin
        report($sformatf("unexpected beat gray=%0d last=%0b", g, last));
        return;
      end
      want = expected_gray.pop_front();
      if (g !== want.gray) report($sformatf("gray %0d, want %0d", g, want.gray));
      if (last !== want.last) report($sformatf("frame_last %0b, want %0b", last, want.last));
    endtask
  endclass

  logic        clk        = 1'b0;
  logic        rst        = 1'b1;
  logic        cfg_valid  = 1'b0;
  logic        cfg_ready;
  logic [31:0] cfg_data   = '0;
  logic        in_valid   = 1'b0;
  logic        in_stall;
  logic        action     = ACT_SCAN;
  logic [31:0] sample     = '0;
  logic        frame_end  = 1'b0;
  logic        out_valid;
  logic        out_stall  = 1'b0;
  logic [7:0]  gray;
  logic        frame_last;

  gray_scoreboard sb = new();
  int idle_pct   = 20;
  int stall_left = 0;
  int cycles     = 0;

  masked_minmax_gray_normalizer DUT (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .action     (action),
    .sample     (sample),
    .frame_end  (frame_end),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .gray       (gray),
    .frame_last (frame_last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  // The receiver stalls in bursts whose rate follows the current idle setting.
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
      if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct / 2)
        stall_left = $urandom_range(1, 11);
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) sb.check_gray(gray, frame_last);
  end

  task automatic send_beat(logic act, logic [31:0] smp, logic fend);
    if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    in_valid  <= 1'b1;
    action    <= act;
    sample    <= smp;
    frame_end <= fend;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_sample(act, smp, fend);
  endtask

  // Scan beats give no result, so settle keeps waiting after the last gray beat.
  task automatic settle();
    in_valid <= 1'b0;
    while (sb.pending() > 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_marker(logic [31:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    sb.marker = value;
  endtask

  function automatic logic [31:0] pick_sample(logic [31:0] base, int spread);
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return base + $urandom_range(0, spread);
    if (r < 75) return sb.marker;
    if (r < 83) return $urandom;
    if (r < 88) return SAMPLE_MIN;
    if (r < 93) return SAMPLE_MAX;
    return base - $urandom_range(0, spread);
  endfunction

  // Mostly whole frames (scan pass then convert pass), with some stray beats
  // and some frames whose convert pass never ends.
  task automatic run_frames(int n);
    int          sent;
    int          kind;
    int          nscan;
    int          nconv;
    int          spread;
    logic [31:0] base;
    logic [31:0] smp;
    sent = 0;
    while (sent < n) begin
      kind   = $urandom_range(0, 99);
      base   = $urandom;
      spread = 1 << $urandom_range(0, 20);
      if (kind < 12) begin
        send_beat(1'($urandom_range(0, 1)), pick_sample(base, spread),
                  1'($urandom_range(0, 1)));
        sent++;
      end else begin
        nscan = $urandom_range(1, 10);
        nconv = $urandom_range(1, 10);
        for (int i = 0; i < nscan; i++) begin
          if (kind < 20) smp = sb.marker;
          else if (kind < 28) smp = base;
          else smp = pick_sample(base, spread);
          send_beat(ACT_SCAN, smp, 1'($urandom_range(0, 7) == 0));
        end
        for (int i = 0; i < nconv; i++)
          send_beat(ACT_CONVERT, pick_sample(base, spread),
                    (i == nconv - 1) && kind < 95);
        sent += nscan + nconv;
      end
    end
  endtask

  initial begin
    logic [31:0] mark;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed beats under the reset marker.
    send_beat(ACT_CONVERT, 32'h0000_0000, 1'b0);
    send_beat(ACT_SCAN,    32'hFFFF_0000, 1'b0);
    send_beat(ACT_CONVERT, 32'hFFFF_0000, 1'b1);
    send_beat(ACT_SCAN,    32'h0001_0000, 1'b0);
    send_beat(ACT_SCAN,    32'h0001_0000, 1'b1);
    send_beat(ACT_CONVERT, 32'h0001_0000, 1'b1);
    send_beat(ACT_SCAN,    SAMPLE_MIN,    1'b0);
    send_beat(ACT_SCAN,    SAMPLE_MAX,    1'b0);
    send_beat(ACT_SCAN,    32'h0000_0000, 1'b0);
    send_beat(ACT_CONVERT, SAMPLE_MIN,    1'b0);
    send_beat(ACT_CONVERT, SAMPLE_MAX,    1'b0);
    send_beat(ACT_CONVERT, 32'h0000_0000, 1'b0);
    send_beat(ACT_CONVERT, 32'hFFFF_0000, 1'b0);
    send_beat(ACT_CONVERT, 32'h4000_0000, 1'b1);
    send_beat(ACT_SCAN,    32'd100,       1'b0);
    send_beat(ACT_SCAN,    32'd200,       1'b0);
    send_beat(ACT_CONVERT, 32'd50,        1'b0);
    send_beat(ACT_CONVERT, 32'd300,       1'b0);
    send_beat(ACT_CONVERT, 32'd150,       1'b0);
    send_beat(ACT_CONVERT, 32'd199,       1'b0);
    send_beat(ACT_CONVERT, 32'd100,       1'b1);

    for (int p = 0; p < 6; p++) begin
      case (p)
        0:       mark = SAMPLE_MIN;
        1:       mark = SAMPLE_MAX;
        2:       mark = 32'h0000_0000;
        4:       mark = mmgn_pkg::MARKER_RESET;
        default: mark = $urandom;
      endcase
      settle();
      write_marker(mark);
      idle_pct = (p == 2) ? 0 : ((p % 2 == 1) ? 35 : 10);
      run_frames(105);
    end

    idle_pct = 0;
    run_frames(60);
    settle();

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
